// ===== rtl/mpp_pkg.sv =====
// Shared constants and types of the map point perspective projection block.
package mpp_pkg;

   localparam int COEF_W    = 32;
   localparam int SHIFT_W   = 3;
   localparam int MAX_SHIFT = 7;
   localparam int CSR_IDX_W = 4;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_XNUM_COEF_X  = 4'd0,
      REG_XNUM_COEF_Y  = 4'd1,
      REG_XNUM_OFFSET  = 4'd2,
      REG_YNUM_COEF_X  = 4'd3,
      REG_YNUM_COEF_Y  = 4'd4,
      REG_YNUM_OFFSET  = 4'd5,
      REG_DEPTH_COEF_Y = 4'd6,
      REG_DEPTH_OFFSET = 4'd7
   } csr_reg_type;

   typedef struct packed {
      logic [SHIFT_W-1:0] shift;
      logic               last;
      logic               zero;
      logic               neg_x;
      logic               neg_y;
      logic               ovf_x;
      logic               ovf_y;
   } side_type;

endpackage

// ===== rtl/mpp_if.sv =====
// Request and response channel interfaces of the projection block.
interface mpp_req_if #(parameter int COORD_BITS = 16);
   logic                         valid;
   logic                         ready;
   logic signed [COORD_BITS-1:0] map_x;
   logic signed [COORD_BITS-1:0] map_y;
   logic [2:0]                   result_shift;
   logic                         last_in;
   modport source (output valid, map_x, map_y, result_shift, last_in, input ready);
   modport sink   (input valid, map_x, map_y, result_shift, last_in, output ready);
endinterface

interface mpp_rsp_if #(parameter int COORD_BITS = 16);
   logic                         valid;
   logic                         ready;
   logic signed [COORD_BITS-1:0] screen_x;
   logic signed [COORD_BITS-1:0] screen_y;
   logic                         dropped;
   logic                         last_out;
   modport source (output valid, screen_x, screen_y, dropped, last_out, input ready);
   modport sink   (input valid, screen_x, screen_y, dropped, last_out, output ready);
endinterface

// ===== rtl/map_point_perspective_projection.sv =====
// Top level of the map point perspective projection pipeline.
// Each request projects one map point: two affine numerators and an affine depth are
// formed from eight Q16.16 registers, both numerators are divided by the depth with
// rounding to nearest and ties to even, shifted right by the request's shift and
// saturated; a zero depth gives zero coordinates and marks the point dropped. The
// block takes one request per clock unless the response side stalls, and the restoring
// divider resolves one quotient bit per stage; a stall holds the whole pipeline in place.
module map_point_perspective_projection #(
   parameter int COORD_BITS = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   mpp_req_if.sink                         req_ch,
   mpp_rsp_if.source                       rsp_ch,
   input  logic                            csr_we,
   input  logic [mpp_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [mpp_pkg::COEF_W-1:0]      csr_wdata
);
   import mpp_pkg::*;

   localparam int CW = COORD_BITS;
   localparam int PW = COEF_W + CW;
   localparam int NW = PW + 2;
   localparam int DW = PW + 1;
   localparam int QB = CW + MAX_SHIFT + 1;
   localparam int RW = NW + QB;
   localparam int RQ = QB + 2;

   logic signed [COEF_W-1:0] coef_ff [8];

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff[0] <= COEF_W'(65536);
         coef_ff[1] <= '0;
         coef_ff[2] <= '0;
         coef_ff[3] <= '0;
         coef_ff[4] <= COEF_W'(65536);
         coef_ff[5] <= '0;
         coef_ff[6] <= '0;
         coef_ff[7] <= COEF_W'(65536);
      end else if (csr_we) begin
         case (csr_index)
            REG_XNUM_COEF_X:  coef_ff[0] <= csr_wdata;
            REG_XNUM_COEF_Y:  coef_ff[1] <= csr_wdata;
            REG_XNUM_OFFSET:  coef_ff[2] <= csr_wdata;
            REG_YNUM_COEF_X:  coef_ff[3] <= csr_wdata;
            REG_YNUM_COEF_Y:  coef_ff[4] <= csr_wdata;
            REG_YNUM_OFFSET:  coef_ff[5] <= csr_wdata;
            REG_DEPTH_COEF_Y: coef_ff[6] <= csr_wdata;
            REG_DEPTH_OFFSET: coef_ff[7] <= csr_wdata;
            default: ;
         endcase
      end
   end

   logic en;
   logic rsp_valid_ff;
   assign en = !rsp_valid_ff || rsp_ch.ready;
   assign req_ch.ready = en;

   // Stage 1: products.
   logic signed [PW-1:0] p_ff [5];
   logic signed [PW-1:0] p_in [5];
   side_type             s1_ff, s1_in;
   logic                 v1_ff;

   always_comb begin
      p_in[0] = coef_ff[0] * req_ch.map_x;
      p_in[1] = coef_ff[1] * req_ch.map_y;
      p_in[2] = coef_ff[3] * req_ch.map_x;
      p_in[3] = coef_ff[4] * req_ch.map_y;
      p_in[4] = coef_ff[6] * req_ch.map_y;
      s1_in       = '0;
      s1_in.shift = req_ch.result_shift;
      s1_in.last  = req_ch.last_in;
   end

   // Stage 2: sums.
   logic signed [NW-1:0] nx_ff, ny_ff, nx_in, ny_in;
   logic signed [DW-1:0] w_ff, w_in;
   side_type             s2_ff;
   logic                 v2_ff;

   always_comb begin
      nx_in = NW'(p_ff[0]) + NW'(p_ff[1]) + NW'(coef_ff[2]);
      ny_in = NW'(p_ff[2]) + NW'(p_ff[3]) + NW'(coef_ff[5]);
      w_in  = DW'(p_ff[4]) + DW'(coef_ff[7]);
   end

   // Stage 3 and divider stages share arrays; entry 0 holds the magnitudes.
   logic [NW-1:0] rx_ff [QB+1];
   logic [NW-1:0] ry_ff [QB+1];
   logic [NW-1:0] rx_in [QB+1];
   logic [NW-1:0] ry_in [QB+1];
   logic [QB-1:0] qx_ff [QB+1];
   logic [QB-1:0] qy_ff [QB+1];
   logic [QB-1:0] qx_in [QB+1];
   logic [QB-1:0] qy_in [QB+1];
   logic [DW-1:0] ad_ff [QB+1];
   logic [DW-1:0] ad_in [QB+1];
   side_type      sd_ff [QB+1];
   side_type      sd_in [QB+1];
   logic          vd_ff [QB+1];

   always_comb begin
      logic [RW-1:0] trial;
      logic          ge_x;
      logic          ge_y;
      rx_in[0] = nx_ff[NW-1] ? NW'(-nx_ff) : NW'(nx_ff);
      ry_in[0] = ny_ff[NW-1] ? NW'(-ny_ff) : NW'(ny_ff);
      ad_in[0] = w_ff[DW-1] ? DW'(-w_ff) : DW'(w_ff);
      qx_in[0] = '0;
      qy_in[0] = '0;
      sd_in[0]       = s2_ff;
      sd_in[0].zero  = (w_ff == '0);
      sd_in[0].neg_x = nx_ff[NW-1] ^ w_ff[DW-1];
      sd_in[0].neg_y = ny_ff[NW-1] ^ w_ff[DW-1];
      sd_in[0].ovf_x = (rx_in[0] >> QB) >= NW'(ad_in[0]);
      sd_in[0].ovf_y = (ry_in[0] >> QB) >= NW'(ad_in[0]);
      for (int k = 0; k < QB; k++) begin
         trial = RW'(ad_ff[k]) << (QB - 1 - k);
         ge_x  = RW'(rx_ff[k]) >= trial;
         ge_y  = RW'(ry_ff[k]) >= trial;
         rx_in[k+1] = ge_x ? NW'(RW'(rx_ff[k]) - trial) : rx_ff[k];
         ry_in[k+1] = ge_y ? NW'(RW'(ry_ff[k]) - trial) : ry_ff[k];
         qx_in[k+1] = {qx_ff[k][QB-2:0], ge_x};
         qy_in[k+1] = {qy_ff[k][QB-2:0], ge_y};
         ad_in[k+1] = ad_ff[k];
         sd_in[k+1] = sd_ff[k];
      end
   end

   // Rounding stage.
   logic signed [RQ-1:0] vx_ff, vy_ff, vx_in, vy_in;
   side_type             sr_ff;
   logic                 vr_ff;

   always_comb begin
      logic [NW:0]   r2x;
      logic [NW:0]   r2y;
      logic [QB:0]   qrx;
      logic [QB:0]   qry;
      logic          upx;
      logic          upy;
      r2x = {rx_ff[QB], 1'b0};
      r2y = {ry_ff[QB], 1'b0};
      upx = (r2x > (NW+1)'(ad_ff[QB])) ||
            ((r2x == (NW+1)'(ad_ff[QB])) && qx_ff[QB][0]);
      upy = (r2y > (NW+1)'(ad_ff[QB])) ||
            ((r2y == (NW+1)'(ad_ff[QB])) && qy_ff[QB][0]);
      qrx = (QB+1)'(qx_ff[QB]) + (QB+1)'(upx);
      qry = (QB+1)'(qy_ff[QB]) + (QB+1)'(upy);
      vx_in = sd_ff[QB].neg_x ? -RQ'(qrx) : RQ'(qrx);
      vy_in = sd_ff[QB].neg_y ? -RQ'(qry) : RQ'(qry);
   end

   // Output stage: shift, saturate, zero depth.
   localparam logic signed [CW-1:0] SAT_MAX = {1'b0, {(CW-1){1'b1}}};
   localparam logic signed [CW-1:0] SAT_MIN = {1'b1, {(CW-1){1'b0}}};

   function automatic logic signed [CW-1:0] finish(input logic signed [RQ-1:0] v,
                                                   input logic [SHIFT_W-1:0] sh,
                                                   input logic ovf, input logic neg);
      logic signed [RQ-1:0] s;
      s = v >>> sh;
      if (ovf) return neg ? SAT_MIN : SAT_MAX;
      if (s > RQ'(SAT_MAX)) return SAT_MAX;
      if (s < RQ'(SAT_MIN)) return SAT_MIN;
      return CW'(s);
   endfunction

   logic signed [CW-1:0] sx_ff, sy_ff, sx_in, sy_in;
   logic                 drop_ff, last_ff;

   always_comb begin
      sx_in = finish(vx_ff, sr_ff.shift, sr_ff.ovf_x, sr_ff.neg_x);
      sy_in = finish(vy_ff, sr_ff.shift, sr_ff.ovf_y, sr_ff.neg_y);
      if (sr_ff.zero) begin
         sx_in = '0;
         sy_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         vr_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int k = 0; k <= QB; k++) vd_ff[k] <= 1'b0;
      end else if (en) begin
         v1_ff        <= req_ch.valid;
         v2_ff        <= v1_ff;
         vd_ff[0]     <= v2_ff;
         for (int k = 0; k < QB; k++) vd_ff[k+1] <= vd_ff[k];
         vr_ff        <= vd_ff[QB];
         rsp_valid_ff <= vr_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 5; i++) p_ff[i] <= p_in[i];
         s1_ff <= s1_in;
         nx_ff <= nx_in;
         ny_ff <= ny_in;
         w_ff  <= w_in;
         s2_ff <= s1_ff;
         for (int k = 0; k <= QB; k++) begin
            rx_ff[k] <= rx_in[k];
            ry_ff[k] <= ry_in[k];
            qx_ff[k] <= qx_in[k];
            qy_ff[k] <= qy_in[k];
            ad_ff[k] <= ad_in[k];
            sd_ff[k] <= sd_in[k];
         end
         vx_ff   <= vx_in;
         vy_ff   <= vy_in;
         sr_ff   <= sd_ff[QB];
         sx_ff   <= sx_in;
         sy_ff   <= sy_in;
         drop_ff <= sr_ff.zero;
         last_ff <= sr_ff.last;
      end
   end

   assign rsp_ch.valid    = rsp_valid_ff;
   assign rsp_ch.screen_x = sx_ff;
   assign rsp_ch.screen_y = sy_ff;
   assign rsp_ch.dropped  = drop_ff;
   assign rsp_ch.last_out = last_ff;

endmodule

// ===== rtl/mpp_checker.sv =====
// Port-level assertions for the projection block and their bind statement.
module mpp_checker #(
   parameter int COORD_BITS = 16
) (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_ready,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input logic [COORD_BITS-1:0] screen_x,
   input logic [COORD_BITS-1:0] screen_y,
   input logic                  dropped
);

   a_ready_tracks_output: assert property (@(posedge clock) disable iff (reset)
      req_ready == (!rsp_valid || rsp_ready))
      else $error("request ready does not follow the output register");

   a_empty_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   a_dropped_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && dropped) |-> (screen_x == '0 && screen_y == '0))
      else $error("dropped point carries nonzero coordinates");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(screen_x) && $stable(screen_y)))
      else $error("stalled response changed");

endmodule

bind map_point_perspective_projection mpp_checker #(.COORD_BITS(COORD_BITS)) u_mpp_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_ch.ready),
   .rsp_valid (rsp_ch.valid),
   .rsp_ready (rsp_ch.ready),
   .screen_x  (rsp_ch.screen_x),
   .screen_y  (rsp_ch.screen_y),
   .dropped   (rsp_ch.dropped)
);
